// ===== rtl/binary_dilation_3x3_defines.svh =====
// assertion macros for the binary dilation block
// used by the top level only, no other dependencies
`ifndef BINARY_DILATION_3X3_DEFINES_SVH
`define BINARY_DILATION_3X3_DEFINES_SVH

// condition must never hold outside reset
`define BDL_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BDL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdl_pkg.sv =====
// shared types and constants for the binary dilation block
// no dependencies
package bdl_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 1024;
    localparam int PIX_W = 8;
    localparam int FW_W = 11;
    localparam int FH_W = 12;
    localparam int CFG_W = 12;
    localparam int ROW_W = FH_W + 1;

    localparam logic [PIX_W-1:0] WHITE = 8'd255;
    localparam logic [PIX_W-1:0] BLACK = 8'd0;
    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // per item control handed from position tracking to window stage
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
        logic cur;
    } t_s1;

endpackage

// ===== rtl/bdl_in_if.sv =====
// input item channel of the binary dilation block
// depends on bdl_pkg
interface bdl_in_if;
    logic                    valid;
    logic                    ready;
    logic [bdl_pkg::PIX_W-1:0] pixel_in;
    logic                    drain;

    modport source (output valid, output pixel_in, output drain, input ready);
    modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

// ===== rtl/bdl_out_if.sv =====
// result item channel of the binary dilation block
// depends on bdl_pkg
interface bdl_out_if;
    logic                    valid;
    logic                    ready;
    logic [bdl_pkg::PIX_W-1:0] pixel_out;
    logic                    frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/binary_dilation_3x3.sv =====
// streaming 3x3 binary dilation, one item per cycle sustained while the output is not back-pressured
// a pixel's result is formed when the item width+1 raster positions later is taken,
// then passes the line buffer read register, then the output register
// throughput set by the single-port-per-side line buffer: one item per cycle while the output is not back-pressured
// synchronous active-low reset clears counters, window and valids; line buffer not cleared
module binary_dilation_3x3 #(
    parameter int unsigned MAX_WIDTH = bdl_pkg::DEF_MAX_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  bdl_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [bdl_pkg::CFG_W-1:0] i_cfg_data,
    bdl_in_if.sink                    i_in,
    bdl_out_if.source                 o_out
);
    import bdl_pkg::*;

    `include "binary_dilation_3x3_defines.svh"

    localparam int XW = $clog2(MAX_WIDTH);

    logic          take, s1_free, wr_en;
    t_s1           s1;
    logic [XW-1:0] rd_addr, wr_addr;
    logic [1:0]    rd_data, wr_data;

    assign i_in.ready = s1_free;

    bdl_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (i_in.valid && s1_free),
        .i_pixel    (i_in.pixel_in),
        .i_drain    (i_in.drain),
        .o_take     (take),
        .o_s1       (s1),
        .o_addr     (rd_addr)
    );

    bdl_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    bdl_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_s1      (s1),
        .i_addr    (rd_addr),
        .i_restart (i_cfg_we),
        .i_rd_data (rd_data),
        .o_s1_free (s1_free),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_out     (o_out)
    );

    `BDL_ASSERT_NEVER(a_pix_binary, i_clk, i_rst_n, o_out.valid && (o_out.pixel_out != BLACK) && (o_out.pixel_out != WHITE), "result pixel not 0 or 255")
    `BDL_ASSERT_NEVER(a_last_black, i_clk, i_rst_n, o_out.valid && o_out.frame_last && (o_out.pixel_out != BLACK), "frame last pixel not black")
    `BDL_ASSERT_NEVER(a_stall_cause, i_clk, i_rst_n, !i_in.ready && !(o_out.valid && !o_out.ready), "input stalled without output backpressure")
    `BDL_ASSERT_NEXT(a_take_adv, i_clk, i_rst_n, take, !s1_free || wr_en || i_in.ready, "stage one lost after take")

endmodule

// ===== rtl/bdl_linebuf.sv =====
// two-row line buffer, one 2-bit word per column, registered read
// no package dependencies
module bdl_linebuf #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output logic [1:0]                   o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [1:0]                   i_wr_data
);

    logic [1:0] r_mem [MAX_WIDTH];
    logic [1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bdl_ctrl.sv =====
// config registers and raster position tracking, classifies each item
// depends on bdl_pkg
module bdl_ctrl #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  bdl_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [bdl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_acc,
    input  logic [bdl_pkg::PIX_W-1:0]     i_pixel,
    input  logic                          i_drain,
    output logic                          o_take,
    output bdl_pkg::t_s1                  o_s1,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_addr
);
    import bdl_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > FW_W) ? WW : FW_W;

    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;
    logic [XW-1:0]    r_x, n_x;
    logic [ROW_W-1:0] r_y, n_y;

    logic [CMP_W-1:0] w_eff, fw_ext, max_c, x_ext, cc;
    logic [ROW_W-1:0] h_eff, cr;
    logic             col_nz, emit, border, last, in_frame;

    always_comb begin
        fw_ext = CMP_W'(r_fw);
        max_c  = CMP_W'(MAX_WIDTH);
        if (r_fw == '0) begin
            w_eff = CMP_W'(1);
        end else if (fw_ext > max_c) begin
            w_eff = max_c;
        end else begin
            w_eff = fw_ext;
        end
        h_eff = (r_fh == '0) ? ROW_W'(1) : ROW_W'(r_fh);

        x_ext    = CMP_W'(r_x);
        col_nz   = (r_x != '0);
        in_frame = (r_y < h_eff);
        emit     = (r_y >= ROW_W'(2)) || ((r_y == ROW_W'(1)) && col_nz);
        cr       = col_nz ? (r_y - ROW_W'(1)) : (r_y - ROW_W'(2));
        cc       = col_nz ? (x_ext - CMP_W'(1)) : (w_eff - CMP_W'(1));
        border   = (cr == '0) || (cr == h_eff - ROW_W'(1)) ||
                   (cc == '0) || (cc == w_eff - CMP_W'(1));
        last     = (cr == h_eff - ROW_W'(1)) && (cc == w_eff - CMP_W'(1));

        // drain before the frame is complete is dropped
        o_take = i_acc && !(i_drain && in_frame);

        o_s1.emit   = emit;
        o_s1.border = border;
        o_s1.last   = last;
        o_s1.cur    = in_frame && (i_pixel == WHITE);

        if (emit && last) begin
            n_x = '0;
            n_y = '0;
        end else if (x_ext + CMP_W'(1) >= w_eff) begin
            n_x = '0;
            n_y = r_y + ROW_W'(1);
        end else begin
            n_x = r_x + XW'(1);
            n_y = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FW_RESET;
            r_fh <= FH_RESET;
            r_x  <= '0;
            r_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_fw <= i_cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_fh <= i_cfg_data[FH_W-1:0];
                default:          r_fw <= r_fw;
            endcase
            r_x <= '0;
            r_y <= '0;
        end else if (o_take) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_addr = r_x;

endmodule

// ===== rtl/bdl_window.sv =====
// window shift, line buffer write-back and output register
// depends on bdl_pkg and bdl_out_if
module bdl_window #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  bdl_pkg::t_s1                  i_s1,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_addr,
    input  logic                          i_restart,
    input  logic [1:0]                    i_rd_data,
    output logic                          o_s1_free,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_wr_addr,
    output logic [1:0]                    o_wr_data,
    bdl_out_if.source                     o_out
);
    import bdl_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);

    logic          r_s1_valid;
    t_s1           r_s1;
    logic [XW-1:0] r_addr;
    logic [8:0]    r_window, n_window;
    logic          r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic          r_out_last;
    logic          adv;

    // rd_data holds {two rows above, one row above}
    assign n_window  = {r_window[5:0], i_rd_data[1], i_rd_data[0], r_s1.cur};
    assign adv       = r_s1_valid && (!r_s1.emit || !r_out_valid || o_out.ready);
    assign o_s1_free = !r_s1_valid || adv;
    assign o_wr_en   = adv;
    assign o_wr_addr = r_addr;
    assign o_wr_data = {i_rd_data[0], r_s1.cur};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= '0;
        end else begin
            if (i_take) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end

            if (adv && r_s1.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_restart) begin
                r_window <= '0;
            end else if (adv) begin
                r_window <= (r_s1.emit && r_s1.last) ? 9'd0 : n_window;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1   <= i_s1;
            r_addr <= i_addr;
        end
        if (adv && r_s1.emit) begin
            r_out_pix  <= (!r_s1.border && (n_window != 9'd0)) ? WHITE : BLACK;
            r_out_last <= r_s1.last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_out  = r_out_pix;
    assign o_out.frame_last = r_out_last;

endmodule
